/* hw/rtl/prc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package prc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
  localparam int SUM_WIDTH   = COORD_WIDTH + 4;
  localparam int CNT_WIDTH   = $clog2(PROD_WIDTH + 1);
  localparam int ADDR_WIDTH  = 4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_BOTTOM = 2'd2,
    REG_TOP    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_MUL,
    ST_DSTART,
    ST_DWAIT,
    ST_ADJ,
    ST_OUT
  } state_t;

  // Divider handshake
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Saturate a widened sum to the coordinate range
  function automatic coord_t sat_coord(input logic signed [SUM_WIDTH-1:0] v);
    logic signed [SUM_WIDTH-1:0] hi;
    logic signed [SUM_WIDTH-1:0] lo;
    hi = SUM_WIDTH'(signed'({1'b0, {(COORD_WIDTH-1){1'b1}}}));
    lo = -hi - SUM_WIDTH'(1);
    if (v > hi) begin
      sat_coord = hi[COORD_WIDTH-1:0];
    end else if (v < lo) begin
      sat_coord = lo[COORD_WIDTH-1:0];
    end else begin
      sat_coord = v[COORD_WIDTH-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/prc_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface prc_req_if import prc_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   req_type;
  coord_t x_coord;
  coord_t y_coord;
  modport source (output valid, req_type, x_coord, y_coord, input ready);
  modport sink (input valid, req_type, x_coord, y_coord, output ready);
endinterface

interface prc_rsp_if import prc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t x_start;
  coord_t y_start;
  coord_t x_end;
  coord_t y_end;
  logic   rejected;
  modport source (output valid, x_start, y_start, x_end, y_end, rejected, input ready);
  modport sink (input valid, x_start, y_start, x_end, y_end, rejected, output ready);
endinterface
`default_nettype wire

/* hw/rtl/prc_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module prc_div import prc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire div_req_t               req,
  input  wire logic [PROD_WIDTH-1:0]  dividend,
  input  wire logic [COORD_WIDTH-1:0] divisor,
  output div_sts_t                    sts,
  output logic [PROD_WIDTH-1:0]       quotient
);

  logic [COORD_WIDTH:0]   rem;
  logic [PROD_WIDTH-1:0]  dvd;
  logic [COORD_WIDTH-1:0] dsr;
  logic [CNT_WIDTH-1:0]   cnt;
  logic                   busy;
  logic                   done;
  logic [COORD_WIDTH:0]   rem_sh;
  logic                   fits;

  // One quotient bit per cycle, restoring
  assign rem_sh = {rem[COORD_WIDTH-1:0], dvd[PROD_WIDTH-1]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_WIDTH'(PROD_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNT_WIDTH'(1);
        if (cnt == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? rem_sh - {1'b0, dsr} : rem_sh;
      dvd <= {dvd[PROD_WIDTH-2:0], fits};
    end
  end

  assign quotient = dvd;
  assign sts.busy = busy;
  assign sts.done = done;

endmodule
`default_nettype wire

/* hw/rtl/polyline_rect_clipper_top.sv */
// Pen-command line clipper. A move beat (req_type 0) sets the pen point and
// gives no result; a line beat to the pen point also gives no result. A line
// beat to a new point is checked against the clip window and, if it is
// trivially rejected, goes straight to the output; else it is walked through
// the edge tests (left, right, bottom, top, each in both directions). Every
// edge that the segment crosses adds a multiply step, a division by one
// shared 64-by-32 divider that yields one quotient bit per cycle, and an
// adjust step. The request side is not ready while an item is at work. Clip
// registers sit on the APB port at byte addresses 0, 4, 8, 12 (left, right,
// bottom, top) and should only be written while idle.
`timescale 1ns / 1ps
`default_nettype none
module polyline_rect_clipper_top import prc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_WIDTH-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  prc_req_if.sink                    req,
  prc_rsp_if.source                  rsp
);

  coord_t clip_left, clip_right, clip_bottom, clip_top;
  coord_t pen_x, pen_y;
  coord_t x0, y0, x1, y1;
  logic   rej;
  logic [2:0] step;
  state_t state, state_next;

  // interpolation operands
  logic [COORD_WIDTH-1:0] md, mt, mden;
  logic                   neg;
  logic                   zden;
  coord_t                 a0;
  logic [PROD_WIDTH-1:0]  prod;
  div_req_t               dreq;
  div_sts_t               dsts;
  logic [PROD_WIDTH-1:0]  quot;

  reg_idx_t widx;
  assign widx   = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= '0;
      clip_right  <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
      clip_bottom <= '0;
      clip_top    <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_LEFT:   clip_left   <= pwdata;
        REG_RIGHT:  clip_right  <= pwdata;
        REG_BOTTOM: clip_bottom <= pwdata;
        REG_TOP:    clip_top    <= pwdata;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (widx)
      REG_LEFT:   prdata = clip_left;
      REG_RIGHT:  prdata = clip_right;
      REG_BOTTOM: prdata = clip_bottom;
      REG_TOP:    prdata = clip_top;
    endcase
  end

  // Select edge and axis for the current step
  coord_t e, p0, p1, o0, o1;
  logic   hit;
  always_comb begin
    unique case (step[2:1])
      2'd0: e = clip_left;
      2'd1: e = clip_right;
      2'd2: e = clip_bottom;
      2'd3: e = clip_top;
    endcase
    p0 = step[2] ? y0 : x0;
    p1 = step[2] ? y1 : x1;
    o0 = step[2] ? x0 : y0;
    o1 = step[2] ? x1 : y1;
    hit = step[0] ? (p1 <= e && p0 > e) : (p1 >= e && p0 < e);
  end

  logic signed [COORD_WIDTH:0] dd, tt, dn;
  always_comb begin
    dd = {o1[COORD_WIDTH-1], o1} - {o0[COORD_WIDTH-1], o0};
    tt = {e[COORD_WIDTH-1], e} - {p0[COORD_WIDTH-1], p0};
    dn = {p1[COORD_WIDTH-1], p1} - {p0[COORD_WIDTH-1], p0};
  end

  function automatic logic [COORD_WIDTH-1:0] mag_clamp(input logic signed [COORD_WIDTH:0] v);
    logic [COORD_WIDTH:0] m;
    m = v[COORD_WIDTH] ? -v : v;
    mag_clamp = m[COORD_WIDTH] ? {COORD_WIDTH{1'b1}} : m[COORD_WIDTH-1:0];
  endfunction

  // Adjusted coordinate
  localparam logic [PROD_WIDTH-1:0] QMAX = PROD_WIDTH'(1) << 34;
  logic [PROD_WIDTH-1:0]       qc;
  logic signed [SUM_WIDTH-1:0] a0w, qw, sum;
  coord_t                      res;
  always_comb begin
    qc  = zden ? '0 : ((quot > QMAX) ? QMAX : quot);
    a0w = SUM_WIDTH'(a0);
    qw  = signed'(qc[SUM_WIDTH-1:0]);
    sum = neg ? a0w - qw : a0w + qw;
    res = sat_coord(sum);
  end

  logic accept, is_line, same, reject_now, out_free, modify_end1;
  assign accept  = req.valid && req.ready;
  assign is_line = req.req_type;
  assign same    = (req.x_coord == pen_x) && (req.y_coord == pen_y);
  assign reject_now =
    (pen_x < clip_left && req.x_coord < clip_left) ||
    (pen_x > clip_right && req.x_coord > clip_right) ||
    (pen_y < clip_bottom && req.y_coord < clip_bottom) ||
    (pen_y > clip_top && req.y_coord > clip_top);
  assign out_free    = !rsp.valid || rsp.ready;
  assign modify_end1 = step[0] ^ step[1];
  assign req.ready   = (state == ST_IDLE);
  assign dreq.start  = (state == ST_DSTART);

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_line && !same) state_next = reject_now ? ST_OUT : ST_EDGE;
      end
      ST_EDGE: begin
        if (hit)               state_next = ST_MUL;
        else if (step == 3'd7) state_next = ST_OUT;
      end
      ST_MUL:    state_next = zden ? ST_ADJ : ST_DSTART;
      ST_DSTART: state_next = ST_DWAIT;
      ST_DWAIT:  if (dsts.done) state_next = ST_ADJ;
      ST_ADJ:    state_next = (step == 3'd7) ? ST_OUT : ST_EDGE;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Pen and working endpoints
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= '0;
      pen_y <= '0;
      step  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && !(is_line && same)) begin
            pen_x <= req.x_coord;
            pen_y <= req.y_coord;
          end
          step <= '0;
        end
        ST_EDGE: if (!hit) step <= step + 3'd1;
        ST_ADJ:  step <= step + 3'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        x1 <= req.x_coord;
        y1 <= req.y_coord;
        x0 <= reject_now ? req.x_coord : pen_x;
        y0 <= reject_now ? req.y_coord : pen_y;
        rej <= reject_now;
      end
      ST_EDGE: begin
        // latch interpolation operands
        md   <= mag_clamp(dd);
        mt   <= mag_clamp(tt);
        mden <= mag_clamp(dn);
        zden <= (dn == '0);
        neg  <= dd[COORD_WIDTH] ^ tt[COORD_WIDTH] ^ dn[COORD_WIDTH];
        a0   <= o0;
      end
      ST_MUL: prod <= PROD_WIDTH'(md) * PROD_WIDTH'(mt);
      ST_ADJ: begin
        // move one endpoint onto the edge
        if (step[2]) begin
          if (modify_end1) begin x1 <= res; y1 <= e; end
          else             begin x0 <= res; y0 <= e; end
        end else begin
          if (modify_end1) begin y1 <= res; x1 <= e; end
          else             begin y0 <= res; x0 <= e; end
        end
      end
      default: ;
    endcase
  end

  prc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .dividend (prod),
    .divisor  (mden),
    .sts      (dsts),
    .quotient (quot)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      rsp.x_start  <= x0;
      rsp.y_start  <= y0;
      rsp.x_end    <= x1;
      rsp.y_end    <= y1;
      rsp.rejected <= rej;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/prc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module prc_checker import prc_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   req_ready,
  input wire logic   rsp_valid,
  input wire logic   rsp_ready,
  input wire logic   rsp_rejected,
  input wire coord_t x_start,
  input wire coord_t y_start,
  input wire coord_t x_end,
  input wire coord_t y_end
);

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid after reset");

  // a rejected result is a single point
  a_rej_point: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_rejected |-> x_start == x_end && y_start == y_end)
    else $error("rejected result is not degenerate");

  // a new result appears only once the request side is open again
  a_new_rsp: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> req_ready)
    else $error("result issued while busy");

endmodule

bind polyline_rect_clipper_top prc_checker u_prc_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_rejected (rsp.rejected),
  .x_start      (rsp.x_start),
  .y_start      (rsp.y_start),
  .x_end        (rsp.x_end),
  .y_end        (rsp.y_end)
);
`default_nettype wire
